// ----- rtl/srfc_pkg.sv -----
package srfc_pkg;

  localparam logic [7:0]  START_BYTE   = 8'hAA;
  localparam logic [7:0]  SUM_A_INIT   = 8'hFF;
  localparam logic [7:0]  SUM_B_INIT   = 8'h00;
  localparam logic [3:0]  HDR_LAST     = 4'd10;
  localparam logic [3:0]  BODY_LAST    = 4'd9;
  localparam logic [15:0] BODY_BYTES   = 16'd10;
  localparam logic [15:0] ERR_LEN      = 16'd12;
  localparam logic [15:0] DATA_LEN_OFS = 16'd11;
  localparam logic [15:0] MAX_LEN_RST  = 16'hFFFF;
  localparam logic [3:0]  IDX_NONE     = 4'hF;

  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HDR_SUM  = 3'd1;
  localparam logic [2:0] ST_BODY_SUM = 3'd2;
  localparam logic [2:0] ST_ERR_RESP = 3'd3;
  localparam logic [2:0] ST_REQUEST  = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR,
    PH_HSUM,
    PH_BODY,
    PH_DATA,
    PH_BSUM
  } phase_t;

  typedef enum logic [2:0] {
    TK_START,
    TK_HDR,
    TK_BODY,
    TK_DATA,
    TK_STAT
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] idx;
    logic [7:0] value;
    logic [2:0] status;
    logic       err_ok;
  } tok_t;

endpackage

// ----- rtl/srfc_if.sv -----
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_end;
  logic [7:0]  data_byte;
  logic [2:0]  status;
  logic [7:0]  svc_code;
  logic [15:0] obj_kind;
  logic [31:0] obj_ident;
  logic [15:0] prop_code;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] data_count;
  logic [15:0] error_code;
  logic        truncated;

  modport source (
    output valid, output frame_end, output data_byte, output status,
    output svc_code, output obj_kind, output obj_ident, output prop_code,
    output source_addr, output dest_addr, output data_count, output error_code,
    output truncated, input ready
  );
  modport sink (
    input valid, input frame_end, input data_byte, input status,
    input svc_code, input obj_kind, input obj_ident, input prop_code,
    input source_addr, input dest_addr, input data_count, input error_code,
    input truncated, output ready
  );
endinterface

// ----- rtl/srfc_front.sv -----
module srfc_front import srfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  srfc_in_if.sink   in_ch,
  input  logic      q_full,
  output logic      q_push,
  output tok_t      q_tok
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  sum_lo_r, sum_lo_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] data_last_r, data_last_nxt;
  logic        flag0_r, flag0_nxt;
  logic        flag1_r, flag1_nxt;
  logic        acc;
  logic [7:0]  b;
  logic [7:0]  sa;
  logic [7:0]  sb;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;
  assign b   = in_ch.rx_byte;
  assign sa  = sum_a_r + b;
  assign sb  = sum_b_r + sa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      sum_a_r <= SUM_A_INIT;
      sum_b_r <= SUM_B_INIT;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_lo_r    <= sum_lo_nxt;
    len_r       <= len_nxt;
    data_last_r <= data_last_nxt;
    flag0_r     <= flag0_nxt;
    flag1_r     <= flag1_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    sum_lo_nxt    = sum_lo_r;
    len_nxt       = len_r;
    data_last_nxt = data_last_r;
    flag0_nxt     = flag0_r;
    flag1_nxt     = flag1_r;
    q_push        = 1'b0;
    q_tok.kind    = TK_START;
    q_tok.idx     = pos_r[3:0];
    q_tok.value   = b;
    q_tok.status  = ST_OK;
    q_tok.err_ok  = 1'b0;
    if (acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            q_push     = 1'b1;
            q_tok.kind = TK_START;
            phase_nxt  = PH_HDR;
            pos_nxt    = '0;
            sum_a_nxt  = SUM_A_INIT;
            sum_b_nxt  = SUM_B_INIT;
          end
        end
        PH_HDR: begin
          sum_a_nxt  = sa;
          sum_b_nxt  = sb;
          q_push     = 1'b1;
          q_tok.kind = TK_HDR;
          if (pos_r[3:0] == 4'd9) begin
            len_nxt[7:0] = b;
          end
          if (pos_r[3:0] == HDR_LAST) begin
            len_nxt[15:8] = b;
            pos_nxt       = '0;
            phase_nxt     = PH_HSUM;
          end else begin
            pos_nxt = pos_r + 16'd1;
          end
        end
        PH_HSUM: begin
          if (pos_r == '0) begin
            sum_lo_nxt = b;
            pos_nxt    = 16'd1;
          end else begin
            pos_nxt = '0;
            if (sum_lo_r != sum_a_r || b != sum_b_r) begin
              q_push       = 1'b1;
              q_tok.kind   = TK_STAT;
              q_tok.status = ST_HDR_SUM;
              phase_nxt    = PH_HUNT;
            end else if (len_r < BODY_BYTES) begin
              q_push       = 1'b1;
              q_tok.kind   = TK_STAT;
              q_tok.status = ST_SHORT;
              phase_nxt    = PH_HUNT;
            end else begin
              sum_a_nxt     = SUM_A_INIT;
              sum_b_nxt     = SUM_B_INIT;
              data_last_nxt = len_r - DATA_LEN_OFS;
              phase_nxt     = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          sum_a_nxt  = sa;
          sum_b_nxt  = sb;
          q_push     = 1'b1;
          q_tok.kind = TK_BODY;
          if (pos_r[3:0] == 4'd0) begin
            flag0_nxt = b[0];
            flag1_nxt = b[1];
          end
          if (pos_r[3:0] == BODY_LAST) begin
            pos_nxt   = '0;
            phase_nxt = (len_r == BODY_BYTES) ? PH_BSUM : PH_DATA;
          end else begin
            pos_nxt = pos_r + 16'd1;
          end
        end
        PH_DATA: begin
          sum_a_nxt  = sa;
          sum_b_nxt  = sb;
          q_push     = 1'b1;
          q_tok.kind = TK_DATA;
          if (pos_r == 16'd0) begin
            q_tok.idx = 4'd0;
          end else if (pos_r == 16'd1) begin
            q_tok.idx = 4'd1;
          end else begin
            q_tok.idx = IDX_NONE;
          end
          if (pos_r == data_last_r) begin
            pos_nxt   = '0;
            phase_nxt = PH_BSUM;
          end else begin
            pos_nxt = pos_r + 16'd1;
          end
        end
        PH_BSUM: begin
          if (pos_r == '0) begin
            sum_lo_nxt = b;
            pos_nxt    = 16'd1;
          end else begin
            pos_nxt      = '0;
            phase_nxt    = PH_HUNT;
            q_push       = 1'b1;
            q_tok.kind   = TK_STAT;
            q_tok.err_ok = (len_r == ERR_LEN);
            if (sum_lo_r != sum_a_r || b != sum_b_r) begin
              q_tok.status = ST_BODY_SUM;
            end else if (flag0_r) begin
              q_tok.status = ST_ERR_RESP;
            end else if (!flag1_r) begin
              q_tok.status = ST_REQUEST;
            end else begin
              q_tok.status = ST_OK;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/srfc_fifo.sv -----
module srfc_fifo import srfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  tok_t tok_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output tok_t tok_o
);

  localparam logic [QAW:0]   DEPTH_C = (QAW + 1)'(QDEPTH);
  localparam logic [QAW-1:0] PTR_ONE = QAW'(1);
  localparam logic [QAW:0]   CNT_ONE = (QAW + 1)'(1);

  tok_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == DEPTH_C);
  assign valid_o = (cnt_r != '0);
  assign tok_o   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + PTR_ONE : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + PTR_ONE : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= tok_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full_o |-> !push_i) else $error("request pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o) else $error("request popped from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("queue count out of range");

endmodule

// ----- rtl/srfc_back.sv -----
module srfc_back import srfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  tok_t        q_tok,
  output logic        q_pop,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  srfc_out_if.source  out_ch
);

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [7:0]  svc_code;
    logic [15:0] obj_kind;
    logic [31:0] obj_ident;
    logic [15:0] prop_code;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] data_count;
    logic [15:0] error_code;
    logic        truncated;
  } res_t;

  logic [15:0] max_len_r;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [7:0]  svc_r, svc_nxt;
  logic [15:0] otype_r, otype_nxt;
  logic [31:0] oid_r, oid_nxt;
  logic [15:0] prop_r, prop_nxt;
  logic [15:0] err_r, err_nxt;
  logic [15:0] dlv_r, dlv_nxt;
  logic        trunc_r, trunc_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;
  logic        slot_free;
  logic        can_dlv;
  logic        needs_out;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign can_dlv   = (dlv_r < max_len_r);
  assign needs_out = (q_tok.kind == TK_STAT) || (q_tok.kind == TK_DATA && can_dlv);
  assign q_pop     = q_valid && (!needs_out || slot_free);

  always_comb begin
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    svc_nxt       = svc_r;
    otype_nxt     = otype_r;
    oid_nxt       = oid_r;
    prop_nxt      = prop_r;
    err_nxt       = err_r;
    dlv_nxt       = dlv_r;
    trunc_nxt     = trunc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (q_pop) begin
      case (q_tok.kind)
        TK_START: begin
          src_nxt   = '0;
          dst_nxt   = '0;
          svc_nxt   = '0;
          otype_nxt = '0;
          oid_nxt   = '0;
          prop_nxt  = '0;
          err_nxt   = '0;
          dlv_nxt   = '0;
          trunc_nxt = 1'b0;
        end
        TK_HDR: begin
          case (q_tok.idx)
            4'd1: src_nxt[7:0]   = q_tok.value;
            4'd2: src_nxt[15:8]  = q_tok.value;
            4'd3: src_nxt[23:16] = q_tok.value;
            4'd4: src_nxt[31:24] = q_tok.value;
            4'd5: dst_nxt[7:0]   = q_tok.value;
            4'd6: dst_nxt[15:8]  = q_tok.value;
            4'd7: dst_nxt[23:16] = q_tok.value;
            4'd8: dst_nxt[31:24] = q_tok.value;
            default: ;
          endcase
        end
        TK_BODY: begin
          case (q_tok.idx)
            4'd1: svc_nxt          = q_tok.value;
            4'd2: otype_nxt[7:0]   = q_tok.value;
            4'd3: otype_nxt[15:8]  = q_tok.value;
            4'd4: oid_nxt[7:0]     = q_tok.value;
            4'd5: oid_nxt[15:8]    = q_tok.value;
            4'd6: oid_nxt[23:16]   = q_tok.value;
            4'd7: oid_nxt[31:24]   = q_tok.value;
            4'd8: prop_nxt[7:0]    = q_tok.value;
            4'd9: prop_nxt[15:8]   = q_tok.value;
            default: ;
          endcase
        end
        TK_DATA: begin
          if (q_tok.idx == 4'd0) begin
            err_nxt[7:0] = q_tok.value;
          end else if (q_tok.idx == 4'd1) begin
            err_nxt[15:8] = q_tok.value;
          end
          if (can_dlv) begin
            res_nxt           = '0;
            res_nxt.data_byte = q_tok.value;
            out_valid_nxt     = 1'b1;
            dlv_nxt           = dlv_r + 16'd1;
          end else begin
            trunc_nxt = 1'b1;
          end
        end
        TK_STAT: begin
          res_nxt.frame_end   = 1'b1;
          res_nxt.data_byte   = '0;
          res_nxt.status      = q_tok.status;
          res_nxt.svc_code    = svc_r;
          res_nxt.obj_kind    = otype_r;
          res_nxt.obj_ident   = oid_r;
          res_nxt.prop_code   = prop_r;
          res_nxt.source_addr = src_r;
          res_nxt.dest_addr   = dst_r;
          res_nxt.data_count  = dlv_r;
          res_nxt.error_code  = (q_tok.status == ST_ERR_RESP && q_tok.err_ok) ? err_r : '0;
          res_nxt.truncated   = trunc_r;
          out_valid_nxt       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    svc_r   <= svc_nxt;
    otype_r <= otype_nxt;
    oid_r   <= oid_nxt;
    prop_r  <= prop_nxt;
    err_r   <= err_nxt;
    dlv_r   <= dlv_nxt;
    trunc_r <= trunc_nxt;
    res_r   <= res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_end   = res_r.frame_end;
  assign out_ch.data_byte   = res_r.data_byte;
  assign out_ch.status      = res_r.status;
  assign out_ch.svc_code    = res_r.svc_code;
  assign out_ch.obj_kind    = res_r.obj_kind;
  assign out_ch.obj_ident   = res_r.obj_ident;
  assign out_ch.prop_code   = res_r.prop_code;
  assign out_ch.source_addr = res_r.source_addr;
  assign out_ch.dest_addr   = res_r.dest_addr;
  assign out_ch.data_count  = res_r.data_count;
  assign out_ch.error_code  = res_r.error_code;
  assign out_ch.truncated   = res_r.truncated;

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.frame_end |-> res_r.status == ST_OK && !res_r.truncated)
    else $error("data result carries status fields");
  a_trunc_set: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_tok.kind == TK_DATA && !can_dlv |=> trunc_r)
    else $error("dropped data byte not flagged");
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && needs_out |-> slot_free)
    else $error("result request popped without free output slot");

endmodule

// ----- rtl/serial_frame_receiver_checker.sv -----
// A byte that yields a result passes through the request queue and then the output register.
// One byte per cycle unless the queue is full; one-step parser, one pop per cycle.
// A four-entry request queue lets the parser keep taking bytes while a result waits.
// Reset (rst_n low at a clock edge): parser hunts for the start byte, queue empties,
// output goes invalid and max_data_len returns to 65535.
module serial_frame_receiver_checker import srfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  srfc_in_if.sink     in_ch,
  srfc_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic q_full;
  logic q_push;
  tok_t q_tok_in;
  logic q_valid;
  logic q_pop;
  tok_t q_tok_out;

  srfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_tok  (q_tok_in)
  );

  srfc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .tok_i   (q_tok_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .tok_o   (q_tok_out)
  );

  srfc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_tok       (q_tok_out),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ch      (out_ch)
  );

endmodule

// ----- bench/tb_serial_frame_receiver_checker.sv -----
`timescale 1ns / 1ps

module tb_serial_frame_receiver_checker import srfc_pkg::*; ();

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;
  localparam int FILL_START  = 3;

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [7:0]  svc_code;
    logic [15:0] obj_kind;
    logic [31:0] obj_ident;
    logic [15:0] prop_code;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] data_count;
    logic [15:0] error_code;
    logic        truncated;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  srfc_in_if  in_ch ();
  srfc_out_if out_ch ();

  serial_frame_receiver_checker i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  frame_result_t results_due[$];
  logic [7:0]    frame_octets[$];

  phase_t      rx_phase;
  logic [15:0] rx_pos;
  logic [7:0]  rx_sum_a;
  logic [7:0]  rx_sum_b;
  logic [7:0]  rx_sum_lo;
  logic [31:0] rx_src;
  logic [31:0] rx_dst;
  logic [15:0] rx_len;
  logic [7:0]  rx_flags;
  logic [7:0]  rx_service;
  logic [15:0] rx_otype;
  logic [31:0] rx_oid;
  logic [15:0] rx_prop;
  logic [15:0] rx_delivered;
  logic [15:0] rx_err_word;
  logic        rx_trunc;
  logic [15:0] rx_limit;

  bit gaps_on = 1'b1;
  int fails = 0;
  int frames_sent = 0;
  int octets_sent = 0;
  int results_checked = 0;
  int limit_writes = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void close_frame(input logic [2:0] st);
    frame_result_t r;
    r = '0;
    r.frame_end   = 1'b1;
    r.status      = st;
    r.svc_code    = rx_service;
    r.obj_kind    = rx_otype;
    r.obj_ident   = rx_oid;
    r.prop_code   = rx_prop;
    r.source_addr = rx_src;
    r.dest_addr   = rx_dst;
    r.data_count  = rx_delivered;
    r.error_code  = (st == ST_ERR_RESP && rx_len == ERR_LEN) ? rx_err_word : 16'h0000;
    r.truncated   = rx_trunc;
    results_due.push_back(r);
    rx_phase = PH_HUNT;
    rx_pos = '0;
  endfunction

  function automatic void track_octet(input logic [7:0] b);
    frame_result_t r;
    case (rx_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          rx_pos = '0;
          rx_sum_a = SUM_A_INIT;
          rx_sum_b = SUM_B_INIT;
          rx_sum_lo = '0;
          rx_src = '0;
          rx_dst = '0;
          rx_len = '0;
          rx_flags = '0;
          rx_service = '0;
          rx_otype = '0;
          rx_oid = '0;
          rx_prop = '0;
          rx_delivered = '0;
          rx_err_word = '0;
          rx_trunc = 1'b0;
          rx_phase = PH_HDR;
        end
      end
      PH_HDR: begin
        rx_sum_a += b;
        rx_sum_b += rx_sum_a;
        if (rx_pos >= 1 && rx_pos <= 4) rx_src[8*(rx_pos-1) +: 8] = b;
        else if (rx_pos >= 5 && rx_pos <= 8) rx_dst[8*(rx_pos-5) +: 8] = b;
        else if (rx_pos == 9) rx_len[7:0] = b;
        else if (rx_pos == 10) rx_len[15:8] = b;
        if (rx_pos == HDR_LAST) begin
          rx_pos = '0;
          rx_phase = PH_HSUM;
        end else begin
          rx_pos++;
        end
      end
      PH_HSUM: begin
        if (rx_pos == 0) begin
          rx_sum_lo = b;
          rx_pos = 1;
        end else if (rx_sum_lo != rx_sum_a || b != rx_sum_b) begin
          close_frame(ST_HDR_SUM);
        end else if (rx_len < BODY_BYTES) begin
          close_frame(ST_SHORT);
        end else begin
          rx_sum_a = SUM_A_INIT;
          rx_sum_b = SUM_B_INIT;
          rx_pos = '0;
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        rx_sum_a += b;
        rx_sum_b += rx_sum_a;
        if (rx_pos == 0) rx_flags = b;
        else if (rx_pos == 1) rx_service = b;
        else if (rx_pos <= 3) rx_otype[8*(rx_pos-2) +: 8] = b;
        else if (rx_pos <= 7) rx_oid[8*(rx_pos-4) +: 8] = b;
        else rx_prop[8*(rx_pos-8) +: 8] = b;
        if (rx_pos == BODY_LAST) begin
          rx_pos = '0;
          if (rx_len == BODY_BYTES) rx_phase = PH_BSUM;
          else rx_phase = PH_DATA;
        end else begin
          rx_pos++;
        end
      end
      PH_DATA: begin
        rx_sum_a += b;
        rx_sum_b += rx_sum_a;
        if (rx_pos == 0) rx_err_word[7:0] = b;
        else if (rx_pos == 1) rx_err_word[15:8] = b;
        if (rx_delivered < rx_limit) begin
          r = '0;
          r.data_byte = b;
          results_due.push_back(r);
          rx_delivered++;
        end else begin
          rx_trunc = 1'b1;
        end
        rx_pos++;
        if (rx_pos >= rx_len - BODY_BYTES) begin
          rx_pos = '0;
          rx_phase = PH_BSUM;
        end
      end
      PH_BSUM: begin
        if (rx_pos == 0) begin
          rx_sum_lo = b;
          rx_pos = 1;
        end else if (rx_sum_lo != rx_sum_a || b != rx_sum_b) begin
          close_frame(ST_BODY_SUM);
        end else if (rx_flags[0]) begin
          close_frame(ST_ERR_RESP);
        end else if (!rx_flags[1]) begin
          close_frame(ST_REQUEST);
        end else begin
          close_frame(ST_OK);
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        rx_pos = '0;
      end
    endcase
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  frame_result_t due_result;
  bit            fields_ok;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, frame_end %0b data_byte %0h status %0d",
                 $time, out_ch.frame_end, out_ch.data_byte, out_ch.status);
        fails++;
      end else begin
        due_result = results_due.pop_front();
        fields_ok = field_ok("frame_end", due_result.frame_end, out_ch.frame_end)
                  & field_ok("data_byte", due_result.data_byte, out_ch.data_byte)
                  & field_ok("status", due_result.status, out_ch.status)
                  & field_ok("svc_code", due_result.svc_code, out_ch.svc_code)
                  & field_ok("obj_kind", due_result.obj_kind, out_ch.obj_kind)
                  & field_ok("obj_ident", due_result.obj_ident, out_ch.obj_ident)
                  & field_ok("prop_code", due_result.prop_code, out_ch.prop_code)
                  & field_ok("source_addr", due_result.source_addr, out_ch.source_addr)
                  & field_ok("dest_addr", due_result.dest_addr, out_ch.dest_addr)
                  & field_ok("data_count", due_result.data_count, out_ch.data_count)
                  & field_ok("error_code", due_result.error_code, out_ch.error_code)
                  & field_ok("truncated", due_result.truncated, out_ch.truncated);
        if (!fields_ok) fails++;
      end
    end
  end

  initial begin : result_sink
    int open_n;
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      open_n = $urandom_range(1, 12);
      repeat (open_n) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic push_octet(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    track_octet(b);
    octets_sent++;
  endtask

  task automatic settle_results();
    int spins;
    in_ch.valid <= 1'b0;
    spins = 0;
    while (results_due.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (8) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      fails++;
      results_due.delete();
    end
  endtask

  task automatic set_data_limit(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    rx_limit = v;
    limit_writes++;
  endtask

  function automatic logic [7:0] fill_octet(input int fill);
    case (fill)
      FILL_ZERO:  return 8'h00;
      FILL_ONES:  return 8'hFF;
      FILL_START: return START_BYTE;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic append_sums(input logic [7:0] sa, input logic [7:0] sb, input bit corrupt);
    logic [7:0] flip;
    flip = 8'($urandom_range(1, 255));
    if (corrupt) begin
      if ($urandom_range(0, 1) == 0) sa ^= flip;
      else sb ^= flip;
    end
    frame_octets.push_back(sa);
    frame_octets.push_back(sb);
  endtask

  task automatic load_frame(input logic [31:0] src, input logic [31:0] dst,
                            input logic [15:0] len, input logic [7:0] bflags,
                            input int fill, input bit bad_hsum, input bit bad_bsum);
    logic [7:0] hdr [11];
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] o;
    hdr[0] = fill_octet(fill);
    for (int i = 0; i < 4; i++) begin
      hdr[1 + i] = src[8*i +: 8];
      hdr[5 + i] = dst[8*i +: 8];
    end
    hdr[9] = len[7:0];
    hdr[10] = len[15:8];
    frame_octets.delete();
    frame_octets.push_back(START_BYTE);
    sa = SUM_A_INIT;
    sb = SUM_B_INIT;
    foreach (hdr[i]) begin
      frame_octets.push_back(hdr[i]);
      sa += hdr[i];
      sb += sa;
    end
    append_sums(sa, sb, bad_hsum);
    frames_sent++;
    if (len < BODY_BYTES) return;
    sa = SUM_A_INIT;
    sb = SUM_B_INIT;
    for (int i = 0; i < len; i++) begin
      o = (i == 0) ? bflags : fill_octet(fill);
      frame_octets.push_back(o);
      sa += o;
      sb += sa;
    end
    append_sums(sa, sb, bad_bsum);
  endtask

  task automatic send_octets(input int first, input int count);
    for (int i = first; i < first + count; i++) push_octet(frame_octets[i]);
  endtask

  task automatic send_frame(input logic [31:0] src, input logic [31:0] dst,
                            input logic [15:0] len, input logic [7:0] bflags,
                            input int fill, input bit bad_hsum, input bit bad_bsum);
    load_frame(src, dst, len, bflags, fill, bad_hsum, bad_bsum);
    send_octets(0, frame_octets.size());
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == START_BYTE) b = 8'h55;
      push_octet(b);
    end
  endtask

  task automatic test_frame_statuses();
    send_frame(32'h0000_0000, 32'hFFFF_FFFF, 16'd14, 8'h02, FILL_ZERO, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'h0000_0000, 16'd14, 8'hFE, FILL_ONES, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd11, 8'h00, FILL_RANDOM, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd12, 8'h01, FILL_RANDOM, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd13, 8'hFF, FILL_ONES, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd10, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
  endtask

  task automatic test_sum_errors();
    send_frame($urandom, $urandom, 16'd13, 8'h02, FILL_RANDOM, 1'b1, 1'b0);
    send_frame($urandom, $urandom, 16'd13, 8'h02, FILL_RANDOM, 1'b1, 1'b0);
    send_frame($urandom, $urandom, 16'd15, 8'h02, FILL_RANDOM, 1'b0, 1'b1);
    send_frame($urandom, $urandom, 16'd10, 8'h01, FILL_RANDOM, 1'b0, 1'b1);
  endtask

  task automatic test_short_lengths();
    send_frame($urandom, $urandom, 16'd0, 8'h02, FILL_ZERO, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd9, 8'h02, FILL_ONES, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd5, 8'h02, FILL_RANDOM, 1'b1, 1'b0);
  endtask

  task automatic test_hunt_and_start_bytes();
    send_noise(12);
    send_frame(32'hAAAA_AAAA, 32'h00AA_00AA, 16'd16, 8'h02, FILL_START, 1'b0, 1'b0);
    load_frame($urandom, $urandom, 16'd14, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
    send_octets(0, 7);
    send_frame($urandom, $urandom, 16'd12, 8'h00, FILL_START, 1'b0, 1'b0);
    send_noise(20);
    send_frame($urandom, $urandom, 16'd11, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
  endtask

  task automatic test_data_limit();
    settle_results();
    set_data_limit(16'd0);
    send_frame($urandom, $urandom, 16'd15, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd10, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
    send_frame($urandom, $urandom, 16'd12, 8'h01, FILL_RANDOM, 1'b0, 1'b0);
    settle_results();
    set_data_limit(16'd3);
    send_frame($urandom, $urandom, 16'd20, 8'h01, FILL_RANDOM, 1'b0, 1'b0);
    settle_results();
    set_data_limit(MAX_LEN_RST);
    // hold the frame after four data bytes, then tighten the limit
    load_frame($urandom, $urandom, 16'd20, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
    send_octets(0, 28);
    settle_results();
    set_data_limit(16'd6);
    send_octets(28, frame_octets.size() - 28);
    settle_results();
    set_data_limit(MAX_LEN_RST);
  endtask

  task automatic test_longest_frame();
    settle_results();
    set_data_limit(16'd5);
    gaps_on = 1'b0;
    send_frame($urandom, $urandom, 16'h0120, 8'h02, FILL_RANDOM, 1'b0, 1'b0);
    settle_results();
    set_data_limit(MAX_LEN_RST);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int pick;
    int cut;
    logic [15:0] len;
    logic [7:0]  bflags;
    sent = 0;
    while (sent < 450) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) len = 16'(10 + $urandom_range(0, 12));
        else if (pick == 7) len = ERR_LEN;
        else if (pick == 8) len = BODY_BYTES;
        else len = 16'(10 + $urandom_range(13, 60));
        bflags = 8'($urandom_range(0, 255));
        if (len == ERR_LEN && $urandom_range(0, 1) == 1) bflags[0] = 1'b1;
        send_frame($urandom, $urandom, len, bflags, FILL_RANDOM,
                   $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0);
        sent += frame_octets.size();
      end else if (pick < 88) begin
        send_frame($urandom, $urandom, 16'($urandom_range(0, 9)), 8'h02, FILL_RANDOM,
                   $urandom_range(0, 7) == 0, 1'b0);
        sent += frame_octets.size();
      end else if (pick < 94) begin
        load_frame($urandom, $urandom, 16'(10 + $urandom_range(0, 12)),
                   8'($urandom_range(0, 255)), FILL_RANDOM, 1'b0, 1'b0);
        cut = $urandom_range(1, frame_octets.size() - 1);
        send_octets(0, cut);
        sent += cut;
      end else begin
        send_noise($urandom_range(1, 8));
      end
      if ($urandom_range(0, 11) == 0) begin
        settle_results();
        case ($urandom_range(0, 5))
          0:       set_data_limit(16'd0);
          1:       set_data_limit(16'($urandom_range(1, 8)));
          2:       set_data_limit(MAX_LEN_RST);
          3:       set_data_limit(16'($urandom_range(0, 65535)));
          default: set_data_limit(16'($urandom_range(9, 40)));
        endcase
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'h0000;
    rx_phase = PH_HUNT;
    rx_pos = '0;
    rx_limit = MAX_LEN_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_statuses();
    test_sum_errors();
    test_short_lengths();
    test_hunt_and_start_bytes();
    test_data_limit();
    test_longest_frame();
    test_random_traffic();
    settle_results();

    $display("Run covered %0d frames in %0d byte requests with %0d data limit writes;",
             frames_sent, octets_sent, limit_writes);
    $display("%0d results compared, %0d failures.", results_checked, fails);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
